[rtl/first_best_fit_block_allocator_defines.svh]
// Assertion macros shared by the block allocator RTL.
`ifndef FIRST_BEST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIRST_BEST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`ifndef SYNTH
// Check on every clock edge outside reset.
`define FBF_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Check on every clock edge, reset included.
`define FBF_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define FBF_ASSERT(lbl, prop, msg)
`define FBF_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[rtl/fbf_pkg.sv]
// Types, codes and defaults of the first-fit / best-fit block allocator.
package fbf_pkg;

   localparam int NUM_BLOCKS_DEFAULT = 16;
   localparam int SIZE_BITS_DEFAULT  = 16;

   localparam int INDEX_BITS = 4;
   localparam int VALUE_BITS = 16;
   localparam int COUNT_BITS = 5;

   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = COUNT_BITS;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_POLICY = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COUNT  = 1'b1;

   localparam logic POLICY_FIRST = 1'b0;
   localparam logic POLICY_BEST  = 1'b1;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_ALLOC = 1'b1;

   localparam logic [COUNT_BITS-1:0] COUNT_RESET = 5'd16;

   typedef struct packed {
      logic                  command;
      logic [INDEX_BITS-1:0] block_index;
      logic [VALUE_BITS-1:0] size_value;
   } req_type;

   typedef struct packed {
      logic                  granted;
      logic [INDEX_BITS-1:0] chosen_block;
      logic [VALUE_BITS-1:0] remaining_after;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic start;
      logic scan;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic scan_done;
   } ctrl_stat_type;

endpackage

[rtl/first_best_fit_block_allocator.sv]
// Top level of the first-fit / best-fit block allocator.
//
// Keeps the free size of each of NUM_BLOCKS memory blocks in a small RAM
// (SIZE_BITS wide). A load item (command 0) writes block_index's size
// and gives no result. An allocate item (command 1) scans blocks 0 up
// to min(block_count, NUM_BLOCKS)-1, one RAM read per cycle, and picks the
// first block that fits (policy_mode 0) or the smallest fitting block, lowest
// index on ties (policy_mode 1). The chosen block is reduced by the request
// in a write-back cycle and one result item reports granted, chosen_block and
// remaining_after, all zero when nothing fits. The block takes one item at a
// time; an allocate walks the table through the single RAM read port. A
// finished result waits in an output register, so the next item is taken
// while it is still pending; a second result stalls in write-back until that
// register is free. Blocks must be loaded before an allocate scans them; the
// table has no reset. Write configuration only while idle.
module first_best_fit_block_allocator
   import fbf_pkg::*;
#(
   parameter int NUM_BLOCKS = NUM_BLOCKS_DEFAULT,
   parameter int SIZE_BITS  = SIZE_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_type                   rsp_data,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   ctrl_cmd_type  cmd;
   ctrl_stat_type stat;

   // sequencing and both handshakes
   fbf_controller u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_data.command),
      .req_ready   (req_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .stat        (stat),
      .cmd         (cmd)
   );

   // table, scan compare, config and result register
   fbf_datapath #(
      .NUM_BLOCKS (NUM_BLOCKS),
      .SIZE_BITS  (SIZE_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req       (req_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp       (rsp_data)
   );

endmodule

[rtl/fbf_ram.sv]
// Generic simple dual-port RAM with registered read.
module fbf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/fbf_datapath.sv]
// Datapath: free-size table, scan compare, config registers and result register.
`include "first_best_fit_block_allocator_defines.svh"
module fbf_datapath
   import fbf_pkg::*;
#(
   parameter int NUM_BLOCKS = NUM_BLOCKS_DEFAULT,
   parameter int SIZE_BITS  = SIZE_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ctrl_cmd_type              cmd,
   output ctrl_stat_type             stat,
   input  req_type                   req,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output rsp_type                   rsp
);

   localparam int IDX_W = $clog2(NUM_BLOCKS);
   localparam int CNT_W = ($clog2(NUM_BLOCKS + 1) > COUNT_BITS) ?
                          $clog2(NUM_BLOCKS + 1) : COUNT_BITS;
   localparam int EXT_W = (SIZE_BITS > VALUE_BITS) ? SIZE_BITS : VALUE_BITS;

   // config
   logic                  policy_ff, policy_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   // scan state
   logic [CNT_W-1:0]      issue_ff, issue_in;
   logic                  rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0]      cmp_idx_ff, cmp_idx_in;
   logic                  found_ff, found_in;
   logic [IDX_W-1:0]      pick_ff, pick_in;
   logic [SIZE_BITS-1:0]  best_ff, best_in;
   logic [VALUE_BITS-1:0] req_ff, req_in;
   rsp_type               rsp_ff, rsp_in;

   logic [CNT_W-1:0]      count_wide;
   logic [CNT_W-1:0]      eff_count;
   logic                  issue;
   logic [SIZE_BITS-1:0]  rd_data;
   logic [EXT_W-1:0]      rd_ext, best_ext, req_ext, diff_ext;
   logic                  fit;
   logic [IDX_W+INDEX_BITS-1:0] load_idx_wide;
   logic [IDX_W+INDEX_BITS-1:0] pick_wide;
   logic [EXT_W-1:0]      load_ext;
   logic                  load_ok;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   logic [SIZE_BITS-1:0]  wr_data;

   // Clamp the block count to the table depth.
   assign count_wide = CNT_W'(count_ff);
   assign eff_count  = (count_wide > CNT_W'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS) : count_wide;

   assign issue = cmd.scan && (issue_ff < eff_count);

   assign rd_ext   = EXT_W'(rd_data);
   assign best_ext = EXT_W'(best_ff);
   assign req_ext  = EXT_W'(req_ff);
   assign diff_ext = best_ext - req_ext;
   assign fit      = rd_ext >= req_ext;

   assign load_idx_wide = {{IDX_W{1'b0}}, req.block_index};
   assign pick_wide     = {{INDEX_BITS{1'b0}}, pick_ff};
   assign load_ext      = EXT_W'(req.size_value);
   assign load_ok       = 32'(req.block_index) < NUM_BLOCKS;

   always_comb begin
      policy_in = policy_ff;
      count_in  = count_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_POLICY: policy_in = csr_wdata[0];
            CSR_COUNT:  count_in  = csr_wdata;
            default:    ;
         endcase
      end
   end

   always_comb begin
      issue_in    = issue_ff;
      rd_valid_in = issue;
      cmp_idx_in  = issue_ff[IDX_W-1:0];
      found_in    = found_ff;
      pick_in     = pick_ff;
      best_in     = best_ff;
      req_in      = req_ff;
      rsp_in      = rsp_ff;
      if (cmd.start) begin
         issue_in    = '0;
         rd_valid_in = 1'b0;
         found_in    = 1'b0;
         req_in      = req.size_value;
      end else begin
         if (issue) begin
            issue_in = issue_ff + 1'b1;
         end
         // Take a fitting entry when none is held yet, or a strictly smaller one in best fit.
         if (rd_valid_ff && fit &&
             (!found_ff || (policy_ff == POLICY_BEST && rd_data < best_ff))) begin
            found_in = 1'b1;
            pick_in  = cmp_idx_ff;
            best_in  = rd_data;
         end
      end
      if (cmd.commit) begin
         rsp_in.granted         = found_ff;
         rsp_in.chosen_block    = found_ff ? pick_wide[INDEX_BITS-1:0] : '0;
         rsp_in.remaining_after = found_ff ? diff_ext[VALUE_BITS-1:0] : '0;
      end
   end

   // Loads and write-back never coincide: loads happen only while idle.
   always_comb begin
      if (cmd.commit) begin
         wr_en   = found_ff;
         wr_addr = pick_ff;
         wr_data = diff_ext[SIZE_BITS-1:0];
      end else begin
         wr_en   = cmd.load && load_ok;
         wr_addr = load_idx_wide[IDX_W-1:0];
         wr_data = load_ext[SIZE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff   <= POLICY_FIRST;
         count_ff    <= COUNT_RESET;
         issue_ff    <= '0;
         rd_valid_ff <= 1'b0;
         found_ff    <= 1'b0;
      end else begin
         policy_ff   <= policy_in;
         count_ff    <= count_in;
         issue_ff    <= issue_in;
         rd_valid_ff <= rd_valid_in;
         found_ff    <= found_in;
      end
      cmp_idx_ff <= cmp_idx_in;
      pick_ff    <= pick_in;
      best_ff    <= best_in;
      req_ff     <= req_in;
      rsp_ff     <= rsp_in;
   end

   fbf_ram #(
      .WIDTH (SIZE_BITS),
      .DEPTH (NUM_BLOCKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (issue),
      .rd_addr (issue_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   assign stat.scan_done = (issue_ff >= eff_count) && !rd_valid_ff;
   assign rsp = rsp_ff;

   `FBF_ASSERT(a_held_fits, found_ff |-> (best_ext >= req_ext), "held block smaller than request")
   `FBF_ASSERT(a_found_from_read, $rose(found_ff) |-> $past(rd_valid_ff), "found without read data")
   `FBF_ASSERT(a_read_in_scan, rd_valid_ff |-> $past(cmd.scan), "read data outside a scan")

endmodule

[rtl/fbf_controller.sv]
// Controller: sequences load, scan and write-back, and owns both handshakes.
`include "first_best_fit_block_allocator_defines.svh"
module fbf_controller
   import fbf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_command,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  ctrl_stat_type stat,
   output ctrl_cmd_type  cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_WRITE = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_command == CMD_ALLOC) begin
                  cmd.start = 1'b1;
                  state_in  = ST_SCAN;
               end else begin
                  cmd.load = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_done) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            // hold the result until the output register is free
            if (slot_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `FBF_ASSERT(a_commit_free, cmd.commit |-> slot_free, "result overwrites a waiting item")
   `FBF_ASSERT(a_rsp_from_commit, $rose(rsp_valid_ff) |-> $past(cmd.commit), "result without commit")
   `FBF_ASSERT(a_start_scans, cmd.start |=> (state_ff == ST_SCAN), "allocation did not scan")
   `FBF_ASSERT_ALWAYS(a_one_write_src, !(cmd.load && cmd.commit), "load and write-back collide")

endmodule
